### rtl/source_line_classifier_core_defines.svh
// Assertion macros for the source line classifier.
`ifndef SOURCE_LINE_CLASSIFIER_CORE_DEFINES_SVH
`define SOURCE_LINE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define SLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slc check failed");

// next-cycle implication
`define SLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slc check failed");

`endif

### rtl/slc_pkg.sv
// Types, constants and helpers shared by the source line classifier.
`default_nettype none
package slc_pkg;

	localparam int COUNT_W = 24;
	localparam int CHAR_W  = 16;

	localparam logic [CHAR_W-1:0] CH_LF     = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] CH_CR     = CHAR_W'(13);
	localparam logic [CHAR_W-1:0] CH_SPACE  = CHAR_W'(32);
	localparam logic [CHAR_W-1:0] CH_DQUOTE = CHAR_W'(34);
	localparam logic [CHAR_W-1:0] CH_QUOTE  = CHAR_W'(39);
	localparam logic [CHAR_W-1:0] CH_LPAREN = CHAR_W'(40);
	localparam logic [CHAR_W-1:0] CH_RPAREN = CHAR_W'(41);
	localparam logic [CHAR_W-1:0] CH_STAR   = CHAR_W'(42);
	localparam logic [CHAR_W-1:0] CH_SLASH  = CHAR_W'(47);
	localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(92);
	localparam logic [CHAR_W-1:0] CH_LBRACE = CHAR_W'(123);
	localparam logic [CHAR_W-1:0] CH_RBRACE = CHAR_W'(125);

	localparam logic LANG_CPP    = 1'b0;
	localparam logic LANG_PASCAL = 1'b1;

	typedef enum logic [7:0] {
		S_NORMAL   = 8'b0000_0001,
		S_OPEN     = 8'b0000_0010,
		S_PAIR     = 8'b0000_0100,
		S_LINECMT  = 8'b0000_1000,
		S_STARCMT  = 8'b0001_0000,
		S_BRACECMT = 8'b0010_0000,
		S_STRING   = 8'b0100_0000,
		S_CLOSED   = 8'b1000_0000
	} scan_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} char_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] code_lines;
		logic [COUNT_W-1:0] comment_lines;
		logic [COUNT_W-1:0] blank_lines;
		logic [COUNT_W-1:0] total_lines;
	} count_item_t;

	// running totals handed from the scanner to the summing stage
	typedef struct packed {
		logic [COUNT_W-1:0] code;
		logic [COUNT_W-1:0] comment;
		logic [COUNT_W-1:0] blank;
		logic [COUNT_W-1:0] dup;
	} counts_t;

	function automatic logic is_break(input logic [CHAR_W-1:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	// saturating add of 0..3 (callers add at most 2)
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] v,
			input logic [1:0] n);
		logic [COUNT_W:0] s;
		s = {1'b0, v} + (COUNT_W+1)'(n);
		return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/slc_scan.sv
// Character scanner: mode tracking, line counters and end-of-file totals.
`default_nettype none
module slc_scan
	import slc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic              last,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic              pas,
	output counts_t                fin
);

	scan_mode_t         mode_q;
	logic [CHAR_W-1:0]  held_q;
	logic               lht_q, bsp_q, code_run_q, line_seen_q, end_code_q;
	counts_t            cnt_q;

	scan_mode_t         m;
	logic [CHAR_W-1:0]  h, c;
	logic               lht, bsp, cr, ls, eic;
	logic               i_code, i_cmt, i_blank, i_dup;
	logic               f_code, f_cmt, f_blank;
	logic               do_norm, brk_c, swallowed, closed, lht_f;
	counts_t            nxt;

	always_comb begin
		m = mode_q; h = held_q; lht = lht_q; bsp = bsp_q;
		cr = code_run_q; ls = line_seen_q; eic = end_code_q;
		i_code = 1'b0; i_cmt = 1'b0; i_blank = 1'b0; i_dup = 1'b0;
		f_code = 1'b0; f_cmt = 1'b0; f_blank = 1'b0;
		do_norm = 1'b0; swallowed = 1'b0; closed = 1'b0; lht_f = 1'b0;
		c = char_code;
		brk_c = is_break(c);

		unique case (mode_q)
			S_OPEN: begin
				h = '0;
				m = S_NORMAL;
				if (held_q == CH_SLASH && c == CH_SLASH) begin
					if (cr) begin i_code = 1'b1; i_dup = 1'b1; end
					lht = 1'b0; ls = 1'b0; cr = 1'b0;
					i_cmt = 1'b1;
					m = S_LINECMT;
				end else if (c == CH_STAR && ((held_q == CH_SLASH && !pas) ||
						(held_q == CH_LPAREN && pas))) begin
					if (cr) begin i_code = 1'b1; i_dup = 1'b1; end
					lht = 1'b0; ls = 1'b0; cr = 1'b0;
					m = S_STARCMT;
				end else begin
					// the held opener was ordinary text after all
					cr = 1'b1; ls = 1'b1;
					if (held_q > CH_SPACE) lht = 1'b1;
					do_norm = 1'b1;
				end
			end
			S_PAIR: begin
				h = '0;
				m = S_NORMAL;
				if (!(brk_c && c != held_q)) do_norm = 1'b1;
			end
			S_LINECMT: begin
				if (brk_c) begin m = S_PAIR; h = c; end
			end
			S_STARCMT: begin
				if (is_break(held_q)) begin
					h = '0;
					swallowed = brk_c && c != held_q;
				end
				if (!swallowed) begin
					if (h == CH_STAR) begin
						h = '0;
						if (c == (pas ? CH_RPAREN : CH_SLASH)) begin
							closed = 1'b1;
							m = S_CLOSED; eic = 1'b0;
						end
					end
					if (!closed) begin
						if (brk_c) begin i_cmt = 1'b1; h = c; end
						else if (c == CH_STAR) h = c;
					end
				end
			end
			S_BRACECMT: begin
				if (is_break(held_q)) begin
					h = '0;
					swallowed = brk_c && c != held_q;
				end
				if (!swallowed) begin
					if (c == CH_RBRACE) begin
						m = S_CLOSED; eic = 1'b0; h = '0;
					end else if (brk_c) begin
						i_cmt = 1'b1; h = c;
					end
				end
			end
			S_STRING: begin
				if (is_break(held_q)) begin
					h = '0;
					swallowed = brk_c && c != held_q;
				end
				if (!swallowed) begin
					if (brk_c) begin
						i_code = 1'b1; h = c; bsp = 1'b0;
					end else if (pas) begin
						if (c == CH_QUOTE) begin m = S_CLOSED; eic = 1'b1; h = c; end
					end else if (c == CH_DQUOTE) begin
						if (!bsp) begin m = S_CLOSED; eic = 1'b1; h = '0; end
						else bsp = 1'b0;
					end else if (c == CH_BSLASH) begin
						bsp = ~bsp;
					end else begin
						bsp = 1'b0;
					end
				end
			end
			S_CLOSED: begin
				// Pascal doubled quote reopens the string
				if (held_q == CH_QUOTE && pas && c == CH_QUOTE) begin
					m = S_STRING; h = '0; bsp = 1'b0;
				end else begin
					h = '0;
					lht = 1'b0; ls = 1'b0; cr = 1'b0;
					if (brk_c) begin
						if (end_code_q) i_code = 1'b1; else i_cmt = 1'b1;
						m = S_PAIR; h = c;
					end else begin
						m = S_NORMAL;
						do_norm = 1'b1;
					end
				end
			end
			default: do_norm = 1'b1;
		endcase

		if (do_norm) begin
			if (brk_c) begin
				if (lht) i_code = 1'b1; else i_blank = 1'b1;
				lht = 1'b0; ls = 1'b1; cr = 1'b0;
				m = S_PAIR; h = c;
			end else if (c == (pas ? CH_QUOTE : CH_DQUOTE)) begin
				lht = 1'b0; ls = 1'b0; cr = 1'b0;
				m = S_STRING; h = '0; bsp = 1'b0;
			end else if (pas && c == CH_LBRACE) begin
				if (cr) begin i_code = 1'b1; i_dup = 1'b1; end
				lht = 1'b0; ls = 1'b0; cr = 1'b0; h = '0;
				m = S_BRACECMT;
			end else if (c == CH_SLASH || (pas && c == CH_LPAREN)) begin
				m = S_OPEN; h = c;
			end else begin
				cr = 1'b1; ls = 1'b1;
				if (c > CH_SPACE) lht = 1'b1;
			end
		end

		// end-of-file closing line, judged on the state after this character
		unique case (m)
			S_OPEN: begin
				lht_f = lht || (h > CH_SPACE);
				if (lht_f) f_code = 1'b1; else f_blank = 1'b1;
			end
			S_NORMAL, S_PAIR: begin
				if (ls) begin
					if (lht) f_code = 1'b1; else f_blank = 1'b1;
				end
			end
			S_STARCMT, S_BRACECMT: f_cmt = 1'b1;
			S_STRING: f_code = 1'b1;
			S_CLOSED: begin
				if (eic) f_code = 1'b1; else f_cmt = 1'b1;
			end
			default: f_code = 1'b0;
		endcase

		nxt.code    = sat_add(cnt_q.code,
				2'(i_code) + 2'(last && f_code));
		nxt.comment = sat_add(cnt_q.comment,
				2'(i_cmt) + 2'(last && f_cmt));
		nxt.blank   = sat_add(cnt_q.blank,
				2'(i_blank) + 2'(last && f_blank));
		nxt.dup     = sat_add(cnt_q.dup, 2'(i_dup));
	end

	assign fin = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= S_NORMAL;
			held_q      <= '0;
			lht_q       <= 1'b0;
			bsp_q       <= 1'b0;
			code_run_q  <= 1'b0;
			line_seen_q <= 1'b0;
			end_code_q  <= 1'b0;
			cnt_q       <= '0;
		end else if (fire) begin
			if (last) begin
				// file done: back to the reset picture for the next file
				mode_q      <= S_NORMAL;
				held_q      <= '0;
				lht_q       <= 1'b0;
				bsp_q       <= 1'b0;
				code_run_q  <= 1'b0;
				line_seen_q <= 1'b0;
				end_code_q  <= 1'b0;
				cnt_q       <= '0;
			end else begin
				mode_q      <= m;
				held_q      <= h;
				lht_q       <= lht;
				bsp_q       <= bsp;
				code_run_q  <= cr;
				line_seen_q <= ls;
				end_code_q  <= eic;
				cnt_q       <= nxt;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/source_line_classifier_core.sv
// Top level of the source line classifier: handshakes, pipeline and totals.
//
//  channel   direction  handshake               payload
//  char      in         char_valid/char_stall   char_item_t  (one character)
//  count     out        count_valid/count_stall count_item_t (four totals)
//  cfg       in         cfg_we                  cfg_wdata    (language mode)
//
// One character per cycle while char_stall is low; the scan state update is the loop that sets it.
// A file's totals leave after its last character is taken, through the input register,
// the count snapshot and the output register.
// Reset clears the scan state, counters, language mode and all valid flags.
// A stall on the count side holds back only a last character when the snapshot
// stage is still occupied; other characters keep flowing.
`default_nettype none
`include "source_line_classifier_core_defines.svh"
module source_line_classifier_core
	import slc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire char_item_t  char_item,
	output logic             count_valid,
	input  wire logic        count_stall,
	output count_item_t      count_item,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata
);

	logic        lang_q;
	logic        vld_s1, vld_s2;
	char_item_t  item_s1;
	counts_t     cnt_s2, fin;
	logic        go1, go2, fire, accept;

	logic [COUNT_W+1:0] sum3, dup_x, diff;
	logic [COUNT_W-1:0] total;

	assign go2    = vld_s2 && (!count_valid || !count_stall);
	assign go1    = !(item_s1.last_char && vld_s2 && !go2);
	assign fire   = vld_s1 && go1;
	assign char_stall = vld_s1 && !go1;
	assign accept = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lang_q <= LANG_CPP;
		else if (cfg_we) lang_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			count_valid <= 1'b0;
		end else begin
			if (accept) vld_s1 <= 1'b1;
			else if (fire) vld_s1 <= 1'b0;

			if (fire && item_s1.last_char) vld_s2 <= 1'b1;
			else if (go2) vld_s2 <= 1'b0;

			if (go2) count_valid <= 1'b1;
			else if (!count_stall) count_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= char_item;
		if (fire && item_s1.last_char) cnt_s2 <= fin;
		if (go2) begin
			count_item.code_lines    <= cnt_s2.code;
			count_item.comment_lines <= cnt_s2.comment;
			count_item.blank_lines   <= cnt_s2.blank;
			count_item.total_lines   <= total;
		end
	end

	slc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.last      (item_s1.last_char),
		.char_code (item_s1.char_code),
		.pas       (lang_q == LANG_PASCAL),
		.fin       (fin)
	);

	// total = code + comment + blank - duplicates, clamped at both ends
	always_comb begin
		sum3  = (COUNT_W+2)'(cnt_s2.code) + (COUNT_W+2)'(cnt_s2.comment)
				+ (COUNT_W+2)'(cnt_s2.blank);
		dup_x = (COUNT_W+2)'(cnt_s2.dup);
		diff  = (sum3 > dup_x) ? (sum3 - dup_x) : '0;
		total = (diff[COUNT_W+1:COUNT_W] != 2'b00) ? {COUNT_W{1'b1}}
				: diff[COUNT_W-1:0];
	end

	`SLC_ASSERT_NOW(a_last_held, clk, arst_n,
		vld_s1 && item_s1.last_char && vld_s2 && !go2, char_stall)
	`SLC_ASSERT_NEXT(a_last_to_s2, clk, arst_n, fire && item_s1.last_char, vld_s2)
	`SLC_ASSERT_NEXT(a_s2_to_out, clk, arst_n, go2, count_valid && !vld_s2 || vld_s2)

endmodule
`default_nettype wire

### tb/tb_source_line_classifier_core.sv
// Testbench for the source line classifier: directed and random source files scored against a line-count predictor.
`timescale 1ns / 100ps
module tb_source_line_classifier_core
	import slc_pkg::*;
;
	localparam int CLK_PERIOD   = 8;
	localparam int IDLE_PCT     = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES   = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_CHARS   = 500;
	localparam int RAND_FILES   = 40;
	localparam int DIR_ROWS     = 27;

	typedef struct packed {
		logic              mode;
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              typed;
		count_item_t       want;
	} dir_row_t;

	localparam count_item_t NO_COUNTS = '0;

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// lone control character: one blank line
		'{LANG_CPP, CHAR_W'(1), 1'b1, 1'b1, '{24'd0, 24'd0, 24'd1, 24'd1}},
		// file ending in a break adds a further blank line
		'{LANG_CPP, CH_LF, 1'b1, 1'b1, '{24'd0, 24'd0, 24'd2, 24'd2}},
		// code then block comment spanning a CR LF
		'{LANG_CPP, CHAR_W'(65535), 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_SLASH, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_STAR, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_CR, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_LF, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_STAR, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_SLASH, 1'b1, 1'b0, NO_COUNTS},
		// escaped quote in a string, break after close, slash held at end of file
		'{LANG_CPP, CH_DQUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_BSLASH, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_DQUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_DQUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_LF, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_SLASH, 1'b1, 1'b0, NO_COUNTS},
		// Pascal: doubled quote, brace comment, line comment at end of file
		'{LANG_PASCAL, CH_QUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_QUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_QUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_QUOTE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_LBRACE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_RBRACE, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_SLASH, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_SLASH, 1'b1, 1'b0, NO_COUNTS},
		// opened as (* in Pascal, closed as */ after switching to C
		'{LANG_PASCAL, CH_LPAREN, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_PASCAL, CH_STAR, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_STAR, 1'b0, 1'b0, NO_COUNTS},
		'{LANG_CPP, CH_SLASH, 1'b1, 1'b0, NO_COUNTS}
	};

	localparam logic [CHAR_W-1:0] SPECIALS [12] = '{
		CH_SLASH, CH_STAR, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
		CH_DQUOTE, CH_QUOTE, CH_BSLASH, CH_CR, CH_LF, CH_SPACE
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	char_item_t  char_item;
	logic        count_valid;
	logic        count_stall;
	count_item_t count_item;
	logic        cfg_we;
	logic        cfg_wdata;

	// predictor state
	logic               lang;
	scan_mode_t         scan_state;
	logic [CHAR_W-1:0]  held;
	logic               line_text, bs_parity, code_run, line_seen, end_code;
	logic [COUNT_W-1:0] n_code, n_comment, n_blank, n_dup;

	count_item_t       pending_counts[$];
	logic [CHAR_W-1:0] file_q[$];

	int  cyc = 0;
	int  n_mismatch = 0;
	int  n_results = 0;
	int  n_chars = 0;
	int  n_files = 0;
	int  n_pas_files = 0;
	int  n_cfg_writes = 0;
	int  hold_req = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  n_holds = 0;
	logic idle_on = 1'b1;

	source_line_classifier_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.count_valid(count_valid),
		.count_stall(count_stall),
		.count_item (count_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles, %0d results pending", cyc,
				pending_counts.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic is_eol(input logic [CHAR_W-1:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic [CHAR_W-1:0] letter();
		return CHAR_W'($urandom_range(97, 122));
	endfunction

	task automatic clear_scan();
		scan_state = S_NORMAL;
		held       = '0;
		line_text  = 1'b0;
		bs_parity  = 1'b0;
		code_run   = 1'b0;
		line_seen  = 1'b0;
		end_code   = 1'b0;
		n_code     = '0;
		n_comment  = '0;
		n_blank    = '0;
		n_dup      = '0;
	endtask

	task automatic clear_line();
		line_text = 1'b0;
		line_seen = 1'b0;
		code_run  = 1'b0;
	endtask

	task automatic take_code(input logic [CHAR_W-1:0] c);
		code_run  = 1'b1;
		line_seen = 1'b1;
		if (c > CH_SPACE)
			line_text = 1'b1;
	endtask

	// code directly ahead of a comment counts once as code and once as a duplicate
	task automatic open_comment();
		if (code_run) begin
			n_code = inc_sat(n_code);
			n_dup  = inc_sat(n_dup);
		end
		clear_line();
		held = '0;
	endtask

	task automatic close_token(input logic as_code, input logic [CHAR_W-1:0] hold);
		scan_state = S_CLOSED;
		end_code   = as_code;
		held       = hold;
	endtask

	task automatic plain_char(input logic [CHAR_W-1:0] c);
		logic pas;
		pas = (lang == LANG_PASCAL);
		if (is_eol(c)) begin
			if (line_text)
				n_code = inc_sat(n_code);
			else
				n_blank = inc_sat(n_blank);
			line_text  = 1'b0;
			line_seen  = 1'b1;
			code_run   = 1'b0;
			scan_state = S_PAIR;
			held       = c;
		end else if (c == (pas ? CH_QUOTE : CH_DQUOTE)) begin
			clear_line();
			scan_state = S_STRING;
			held       = '0;
			bs_parity  = 1'b0;
		end else if (pas && c == CH_LBRACE) begin
			open_comment();
			scan_state = S_BRACECMT;
		end else if (c == CH_SLASH || (pas && c == CH_LPAREN)) begin
			scan_state = S_OPEN;
			held       = c;
		end else begin
			take_code(c);
		end
	endtask

	// second half of a CR LF / LF CR pair is dropped
	task automatic pair_done(input logic [CHAR_W-1:0] c, output logic swallow);
		logic [CHAR_W-1:0] h;
		swallow = 1'b0;
		if (is_eol(held)) begin
			h       = held;
			held    = '0;
			swallow = is_eol(c) && c != h;
		end
	endtask

	task automatic classify_char(input char_item_t it);
		logic [CHAR_W-1:0]  c, h;
		logic               pas, sw, shut;
		logic [COUNT_W+1:0] sum;
		count_item_t        r;
		c   = it.char_code;
		pas = (lang == LANG_PASCAL);
		case (scan_state)
		S_OPEN: begin
			h          = held;
			held       = '0;
			scan_state = S_NORMAL;
			if (h == CH_SLASH && c == CH_SLASH) begin
				open_comment();
				n_comment  = inc_sat(n_comment);
				scan_state = S_LINECMT;
			end else if (c == CH_STAR && ((h == CH_SLASH && !pas) || (h == CH_LPAREN && pas))) begin
				open_comment();
				scan_state = S_STARCMT;
			end else begin
				take_code(h);
				plain_char(c);
			end
		end
		S_PAIR: begin
			h          = held;
			held       = '0;
			scan_state = S_NORMAL;
			if (!(is_eol(c) && c != h))
				plain_char(c);
		end
		S_LINECMT: begin
			if (is_eol(c)) begin
				scan_state = S_PAIR;
				held       = c;
			end
		end
		S_STARCMT: begin
			pair_done(c, sw);
			shut = 1'b0;
			if (!sw && held == CH_STAR) begin
				held = '0;
				if (c == (pas ? CH_RPAREN : CH_SLASH)) begin
					close_token(1'b0, '0);
					shut = 1'b1;
				end
			end
			if (!sw && !shut) begin
				if (is_eol(c)) begin
					n_comment = inc_sat(n_comment);
					held      = c;
				end else if (c == CH_STAR) begin
					held = c;
				end
			end
		end
		S_BRACECMT: begin
			pair_done(c, sw);
			if (!sw) begin
				if (c == CH_RBRACE) begin
					close_token(1'b0, '0);
				end else if (is_eol(c)) begin
					n_comment = inc_sat(n_comment);
					held      = c;
				end
			end
		end
		S_STRING: begin
			pair_done(c, sw);
			if (!sw) begin
				if (is_eol(c)) begin
					n_code    = inc_sat(n_code);
					held      = c;
					bs_parity = 1'b0;
				end else if (pas) begin
					if (c == CH_QUOTE)
						close_token(1'b1, c);
				end else if (c == CH_DQUOTE) begin
					if (!bs_parity)
						close_token(1'b1, '0);
					else
						bs_parity = 1'b0;
				end else if (c == CH_BSLASH) begin
					bs_parity = ~bs_parity;
				end else begin
					bs_parity = 1'b0;
				end
			end
		end
		S_CLOSED: begin
			// a quote straight after a closing quote reopens the Pascal string
			if (held == CH_QUOTE && pas && c == CH_QUOTE) begin
				scan_state = S_STRING;
				held       = '0;
				bs_parity  = 1'b0;
			end else begin
				held = '0;
				clear_line();
				if (is_eol(c)) begin
					if (end_code)
						n_code = inc_sat(n_code);
					else
						n_comment = inc_sat(n_comment);
					scan_state = S_PAIR;
					held       = c;
				end else begin
					scan_state = S_NORMAL;
					plain_char(c);
				end
			end
		end
		default: plain_char(c);
		endcase

		if (it.last_char) begin
			case (scan_state)
			S_OPEN: begin
				take_code(held);
				if (line_text)
					n_code = inc_sat(n_code);
				else
					n_blank = inc_sat(n_blank);
			end
			S_NORMAL, S_PAIR: begin
				if (line_seen) begin
					if (line_text)
						n_code = inc_sat(n_code);
					else
						n_blank = inc_sat(n_blank);
				end
			end
			S_STARCMT, S_BRACECMT: n_comment = inc_sat(n_comment);
			S_STRING: n_code = inc_sat(n_code);
			S_CLOSED: begin
				if (end_code)
					n_code = inc_sat(n_code);
				else
					n_comment = inc_sat(n_comment);
			end
			default: ;
			endcase
			sum = {2'b00, n_code} + {2'b00, n_comment} + {2'b00, n_blank};
			sum = (sum > {2'b00, n_dup}) ? sum - {2'b00, n_dup} : '0;
			r.code_lines    = n_code;
			r.comment_lines = n_comment;
			r.blank_lines   = n_blank;
			r.total_lines   = (sum[COUNT_W+1:COUNT_W] != 0) ? '1 : sum[COUNT_W-1:0];
			pending_counts.push_back(r);
			clear_scan();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
			input logic [COUNT_W-1:0] want);
		$display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
		n_mismatch++;
	endtask

	task automatic check_counts(input count_item_t got);
		count_item_t want;
		if (pending_counts.size() == 0) begin
			report_mismatch("count transfer with none pending, total", got.total_lines, '0);
		end else begin
			want = pending_counts.pop_front();
			if (got.code_lines !== want.code_lines)
				report_mismatch("code_lines", got.code_lines, want.code_lines);
			if (got.comment_lines !== want.comment_lines)
				report_mismatch("comment_lines", got.comment_lines, want.comment_lines);
			if (got.blank_lines !== want.blank_lines)
				report_mismatch("blank_lines", got.blank_lines, want.blank_lines);
			if (got.total_lines !== want.total_lines)
				report_mismatch("total_lines", got.total_lines, want.total_lines);
		end
	endtask

	// one character transfer; valid stays high afterwards for a back-to-back follower
	task automatic send_char(input char_item_t it, input logic typed, input count_item_t want);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= it;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		classify_char(it);
		if (typed && it.last_char)
			pending_counts[pending_counts.size() - 1] = want;
		n_chars++;
		if (it.last_char)
			n_files++;
	endtask

	// mode writes only once every file in flight has reported and the pipe has emptied
	task automatic set_mode(input logic m);
		char_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		lang = m;
		n_cfg_writes++;
	endtask

	task automatic build_file(input logic pas, input int len);
		int                k, n;
		logic              brace;
		logic [CHAR_W-1:0] ch, q;
		file_q.delete();
		while (file_q.size() < len) begin
			k = $urandom_range(0, 19);
			n = $urandom_range(1, 4);
			if (k <= 4) begin
				repeat (n)
					file_q.push_back(($urandom_range(0, 9) == 0) ?
						CHAR_W'($urandom_range(127, 65535)) : letter());
			end else if (k <= 6) begin
				repeat (n) begin
					ch = CHAR_W'($urandom_range(1, 32));
					file_q.push_back(is_eol(ch) ? CH_SPACE : ch);
				end
			end else if (k <= 9) begin
				case ($urandom_range(0, 4))
				0: file_q.push_back(CH_LF);
				1: file_q.push_back(CH_CR);
				2: begin
					file_q.push_back(CH_CR);
					file_q.push_back(CH_LF);
				end
				3: begin
					file_q.push_back(CH_LF);
					file_q.push_back(CH_CR);
				end
				default: begin
					file_q.push_back(CH_LF);
					file_q.push_back(CH_LF);
				end
				endcase
			end else if (k <= 11) begin
				q = pas ? CH_QUOTE : CH_DQUOTE;
				file_q.push_back(q);
				repeat (n) begin
					case ($urandom_range(0, 5))
					0: file_q.push_back(CH_BSLASH);
					1: begin
						file_q.push_back(pas ? q : CH_BSLASH);
						file_q.push_back(q);
					end
					2: file_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
					default: file_q.push_back(letter());
					endcase
				end
				if ($urandom_range(0, 9) != 0)
					file_q.push_back(q);
			end else if (k <= 13) begin
				file_q.push_back(CH_SLASH);
				file_q.push_back(CH_SLASH);
				repeat (n)
					file_q.push_back($urandom_range(0, 3) ? letter() : CH_SPACE);
				if ($urandom_range(0, 4) != 0) begin
					if ($urandom_range(0, 1))
						file_q.push_back(CH_CR);
					file_q.push_back(CH_LF);
				end
			end else if (k <= 16) begin
				brace = pas && $urandom_range(0, 1);
				if (brace) begin
					file_q.push_back(CH_LBRACE);
				end else begin
					file_q.push_back(pas ? CH_LPAREN : CH_SLASH);
					file_q.push_back(CH_STAR);
				end
				repeat (n) begin
					case ($urandom_range(0, 4))
					0: file_q.push_back(CH_STAR);
					1: file_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
					2: file_q.push_back(CH_SLASH);
					default: file_q.push_back(letter());
					endcase
				end
				if ($urandom_range(0, 6) != 0) begin
					if (brace) begin
						file_q.push_back(CH_RBRACE);
					end else begin
						file_q.push_back(CH_STAR);
						file_q.push_back(pas ? CH_RPAREN : CH_SLASH);
					end
				end
			end else begin
				file_q.push_back($urandom_range(0, 1) ? SPECIALS[$urandom_range(0, 11)] :
					CHAR_W'($urandom_range(1, 65535)));
			end
		end
		while (file_q.size() > len)
			void'(file_q.pop_back());
	endtask

	// result side: scoring plus random and long hold-off stalls
	initial begin
		count_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (count_valid === 1'b1 && !count_stall) begin
				check_counts(count_item);
				n_results++;
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
				n_holds++;
			end
			if (hold_left != 0)
				hold_left--;
			count_stall <= (hold_left != 0) || (idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial begin
		char_item_t it;
		int         f, i, len, flip_at;
		logic       squeeze;
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_item  = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = LANG_CPP;
		lang       = LANG_CPP;
		clear_scan();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(LANG_CPP);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].mode != lang)
				set_mode(DIR_TAB[i].mode);
			it.char_code = DIR_TAB[i].ch;
			it.last_char = DIR_TAB[i].last;
			send_char(it, DIR_TAB[i].typed, DIR_TAB[i].want);
		end

		for (f = 0; n_chars < RAND_CHARS + DIR_ROWS || f < RAND_FILES; f++) begin
			idle_on = (f < 12 || f >= 20);
			// short files under a long result hold-off fill the pipe
			squeeze = (f >= 25 && f < 35);
			if (f == 25)
				hold_req++;
			if (!squeeze && $urandom_range(0, 2) == 0)
				set_mode(LANG_CPP ^ 1'($urandom_range(0, 1)));
			len = squeeze ? $urandom_range(2, 6) : $urandom_range(3, 28);
			build_file(lang == LANG_PASCAL, len);
			flip_at = (!squeeze && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : -1;
			if (lang == LANG_PASCAL)
				n_pas_files++;
			for (i = 0; i < file_q.size(); i++) begin
				if (i == flip_at)
					set_mode(~lang);
				it.char_code = file_q[i];
				it.last_char = (i == file_q.size() - 1);
				send_char(it, 1'b0, NO_COUNTS);
			end
		end
		char_valid <= 1'b0;

		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		$display("Covered %0d characters in %0d files (%0d random files in Pascal), %0d mode writes",
			n_chars, n_files, n_pas_files, n_cfg_writes);
		$display("Scored %0d count transfers, %0d long result hold-offs, %0d mismatches",
			n_results, n_holds, n_mismatch);
		if (n_mismatch == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/slc_pkg.sv
rtl/slc_scan.sv
rtl/source_line_classifier_core.sv
tb/tb_source_line_classifier_core.sv
